// ===== rtl/core/sdsm_pkg.sv =====
// Package for the SD SPI-mode host engine: codes, field widths, defaults.
// No dependencies.
package sdsm_pkg;
  localparam int BlockBytes = 512;
  localparam int CountBits  = 16;
  localparam int TimerBits  = 12;
  localparam int CfgBits    = 12;

  typedef enum logic [2:0] {
    REQ_INIT = 3'd0, REQ_READ = 3'd1, REQ_WRITE = 3'd2, REQ_BYTE = 3'd3, REQ_TICK = 3'd4
  } req_t;

  localparam logic [1:0] CFG_IDLE  = 2'd0;
  localparam logic [1:0] CFG_INIT  = 2'd1;
  localparam logic [1:0] CFG_READY = 2'd2;
  localparam logic [1:0] CFG_TOKEN = 2'd3;

  typedef enum logic [3:0] {
    R_CMD0, R_CMD8, R_V2_55, R_V2_41, R_V2_58, R_V1_55, R_V1_41, R_V1L_55,
    R_V1L_41, R_V1L_1, R_CMD16, R_RD_CMD, R_RD12, R_WR55, R_WR23, R_WR_CMD
  } resume_t;
endpackage

// ===== rtl/core/sd_spi_mode_host_engine.sv =====
// SD card SPI-mode host engine, one item per transfer.
// Result registered in the cycle after the input transfer.
// Throughput: one item per cycle while the output side takes results.
// Reset (rst_n sync low): idle, no card, config registers at defaults.
// One decode step sits between the input transfer and the output register.
module sd_spi_mode_host_engine #(
  parameter int COUNT_BITS = sdsm_pkg::CountBits,
  parameter int TIMER_BITS = sdsm_pkg::TimerBits
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [sdsm_pkg::CfgBits-1:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // req_type
  input  logic [COUNT_BITS+47:0] in_tdata, // sector, block_count, rx_byte, wr_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // tx_valid, tx_byte, card_select, rd_valid, rd_byte, wr_taken, done_res,
  // failed, card_kind, fast_clock (pad to 32)
  output logic [31:0] out_tdata
);
  import sdsm_pkg::*;

  typedef enum logic [4:0] {
    P_IDLE, P_PWR_CLK, P_PWR_PRE, P_PWR_CMD0, P_PWR_POLL, P_PWR_END,
    P_CMD_READY, P_CMD_SEND, P_CMD_STUFF, P_CMD_RESP, P_OCR8, P_OCR58,
    P_INIT_END, P_RD_TOKEN, P_RD_DATA, P_RD_CRC, P_WR_READY, P_WR_TOKEN,
    P_WR_DATA, P_WR_CRC, P_WR_RESP, P_WR_BUSY, P_STOP_READY1, P_STOP_TOKEN,
    P_STOP_READY2, P_XFER_END
  } phase_t;

  localparam int CW = COUNT_BITS;
  localparam int TW = TIMER_BITS;

  logic [11:0] idle_w_r, init_w_r, ready_w_r, token_w_r;
  phase_t phase_r, phase_nxt;
  resume_t resume_r, resume_nxt;
  logic [9:0] bidx_r, bidx_nxt;
  logic [6:0] poll_r, poll_nxt;
  logic [31:0] addr_r, addr_nxt, ocr_r, ocr_nxt, arg_r, arg_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic [2:0] kind_r, kind_nxt, itype_r, itype_nxt;
  logic [TW-1:0] mst_r, mst_nxt, lpt_r, lpt_nxt;
  logic [7:0] last_r, last_nxt;
  logic [5:0] code_r, code_nxt;
  logic multi_r, multi_nxt, fast_r, fast_nxt;
  logic [31:0] res_r;
  logic vld_r;

  logic acc;
  assign in_tready = !vld_r || out_tready;
  assign acc = in_tvalid && in_tready;
  assign out_tvalid = vld_r;
  assign out_tdata = res_r;

  logic [31:0] sec;
  logic [CW-1:0] cnt;
  logic [7:0] rx, wr;
  assign sec = in_tdata[31:0];
  assign cnt = in_tdata[CW+31:32];
  assign rx  = in_tdata[CW+39:CW+32];
  assign wr  = in_tdata[CW+47:CW+40];

  // result fields
  logic txv, cs, rdv, wtk, dn, fl;
  logic [7:0] txb, rdb;

  function automatic logic [TW-1:0] tm(input logic [11:0] v);
    logic [TW+11:0] z;
    z = {{TW{1'b0}}, v};
    return z[TW-1:0];
  endfunction

  function automatic logic [7:0] cmdb(input logic [9:0] i, input logic [5:0] c,
                                     input logic [31:0] a);
    case (i)
      10'd0: cmdb = {2'b01, c};
      10'd1: cmdb = a[31:24];
      10'd2: cmdb = a[23:16];
      10'd3: cmdb = a[15:8];
      10'd4: cmdb = a[7:0];
      default: cmdb = (c == 6'd0) ? 8'h95 : (c == 6'd8) ? 8'h87 : 8'h01;
    endcase
  endfunction

  always_comb begin
    logic [9:0] bi1;
    logic [6:0] pc;
    logic [31:0] ow;
    logic ok, lt0;
    logic [3:0] act; // deferred action
    phase_nxt = phase_r; resume_nxt = resume_r; bidx_nxt = bidx_r; poll_nxt = poll_r;
    addr_nxt = addr_r; ocr_nxt = ocr_r; arg_nxt = arg_r; left_nxt = left_r;
    kind_nxt = kind_r; itype_nxt = itype_r; mst_nxt = mst_r; lpt_nxt = lpt_r;
    last_nxt = last_r; code_nxt = code_r; multi_nxt = multi_r; fast_nxt = fast_r;
    txv = 1'b0; txb = 8'hFF; cs = 1'b0; rdv = 1'b0; rdb = 8'h00; wtk = 1'b0;
    dn = 1'b0; fl = 1'b0;
    bi1 = bidx_r + 10'd1;
    pc = poll_r; ow = 32'd0; ok = 1'b0; lt0 = 1'b0; act = 4'd0;
    // act: 1 after_cmd, 2 read_block_end, 3 write_block_end
    case (in_tuser)
      REQ_INIT: if (phase_r == P_IDLE) begin
        kind_nxt = 3'd0; itype_nxt = 3'd0; fast_nxt = 1'b0;
        phase_nxt = P_PWR_CLK; bidx_nxt = '0; txv = 1'b1;
      end
      REQ_READ, REQ_WRITE: if (phase_r == P_IDLE) begin
        if (cnt == '0 || kind_r == 3'd0) begin
          dn = 1'b1; fl = 1'b1;
        end else begin
          addr_nxt = (kind_r == 3'd4) ? sec : {sec[22:0], 9'd0};
          left_nxt = cnt; multi_nxt = (cnt != {{(CW-1){1'b0}}, 1'b1});
          phase_nxt = P_CMD_READY; mst_nxt = tm(ready_w_r); arg_nxt = addr_nxt;
          txv = 1'b1; cs = 1'b1;
          if (in_tuser == REQ_READ) begin
            code_nxt = multi_nxt ? 6'd18 : 6'd17; resume_nxt = R_RD_CMD;
          end else if (!multi_nxt || kind_r < 3'd2) begin
            code_nxt = multi_nxt ? 6'd25 : 6'd24; resume_nxt = R_WR_CMD;
          end else begin
            code_nxt = 6'd55; arg_nxt = '0; resume_nxt = R_WR55;
          end
        end
      end
      REQ_TICK: begin
        if (mst_r != '0) mst_nxt = mst_r - 1'b1;
        if (lpt_r != '0) lpt_nxt = lpt_r - 1'b1;
      end
      REQ_BYTE: begin
        case (phase_r)
          P_PWR_CLK: begin
            bidx_nxt = bi1; txv = 1'b1;
            if (bi1 >= 10'd10) begin phase_nxt = P_PWR_PRE; bidx_nxt = '0; cs = 1'b1; end
          end
          P_PWR_PRE: begin
            bidx_nxt = bi1; txv = 1'b1; cs = 1'b1;
            if (bi1 >= 10'd2) begin
              phase_nxt = P_PWR_CMD0; bidx_nxt = '0; code_nxt = '0; arg_nxt = '0;
              txb = 8'h40;
            end
          end
          P_PWR_CMD0: begin
            bidx_nxt = bi1; txv = 1'b1; cs = 1'b1;
            if (bi1 < 10'd6) txb = cmdb(bi1, code_r, arg_r);
            else begin mst_nxt = tm(idle_w_r); phase_nxt = P_PWR_POLL; end
          end
          P_PWR_POLL: begin
            txv = 1'b1;
            if (rx == 8'h01 || mst_r == '0) begin last_nxt = rx; phase_nxt = P_PWR_END; end
            else cs = 1'b1;
          end
          P_PWR_END: begin
            if (last_r == 8'h01) begin
              code_nxt = 6'd0; arg_nxt = '0; resume_nxt = R_CMD0; mst_nxt = tm(ready_w_r);
              phase_nxt = P_CMD_READY; txv = 1'b1; cs = 1'b1;
            end else begin
              kind_nxt = '0; phase_nxt = P_IDLE; dn = 1'b1; fl = 1'b1;
            end
          end
          P_CMD_READY: begin
            if (rx == 8'hFF) begin
              phase_nxt = P_CMD_SEND; bidx_nxt = '0; txv = 1'b1; cs = 1'b1;
              txb = cmdb(10'd0, code_r, arg_r);
            end else if (mst_r == '0) begin last_nxt = 8'hFF; act = 4'd1; end
            else begin txv = 1'b1; cs = 1'b1; end
          end
          P_CMD_SEND: begin
            bidx_nxt = bi1; txv = 1'b1; cs = 1'b1;
            if (bi1 < 10'd6) txb = cmdb(bi1, code_r, arg_r);
            else begin
              poll_nxt = 7'd32; phase_nxt = (code_r == 6'd12) ? P_CMD_STUFF : P_CMD_RESP;
            end
          end
          P_CMD_STUFF: begin phase_nxt = P_CMD_RESP; txv = 1'b1; cs = 1'b1; end
          P_CMD_RESP: begin
            if (poll_r != '0) pc = poll_r - 7'd1;
            poll_nxt = pc;
            if (rx[7] && pc != '0) begin txv = 1'b1; cs = 1'b1; end
            else begin last_nxt = rx; act = 4'd1; end
          end
          P_OCR8, P_OCR58: begin
            ow = {ocr_r[23:0], rx}; ocr_nxt = ow; bidx_nxt = bi1;
            if (bi1 < 10'd4) begin txv = 1'b1; cs = 1'b1; end
            else if (phase_r == P_OCR58) begin
              itype_nxt = ow[30] ? 3'd4 : 3'd3; kind_nxt = itype_nxt;
              phase_nxt = P_INIT_END; txv = 1'b1;
            end else if (ow[15:0] == 16'h01AA) begin
              lpt_nxt = tm(init_w_r); code_nxt = 6'd55; arg_nxt = '0; resume_nxt = R_V2_55;
              mst_nxt = tm(ready_w_r); phase_nxt = P_CMD_READY; txv = 1'b1; cs = 1'b1;
            end else begin
              itype_nxt = '0; kind_nxt = '0; phase_nxt = P_INIT_END; txv = 1'b1;
            end
          end
          P_INIT_END: begin
            fast_nxt = (itype_r != '0); phase_nxt = P_IDLE; dn = 1'b1; fl = (itype_r == '0);
          end
          P_RD_TOKEN: begin
            if (rx == 8'hFF && lpt_r != '0) begin txv = 1'b1; cs = 1'b1; end
            else if (rx != 8'hFE) begin ok = 1'b0; act = 4'd2; end
            else begin phase_nxt = P_RD_DATA; bidx_nxt = '0; txv = 1'b1; cs = 1'b1; end
          end
          P_RD_DATA: begin
            rdv = 1'b1; rdb = rx; bidx_nxt = bi1; txv = 1'b1; cs = 1'b1;
            if (bi1 == 10'(BlockBytes)) begin phase_nxt = P_RD_CRC; bidx_nxt = '0; end
          end
          P_RD_CRC: begin
            bidx_nxt = bi1;
            if (bi1 < 10'd2) begin txv = 1'b1; cs = 1'b1; end
            else begin ok = 1'b1; act = 4'd2; end
          end
          P_WR_READY: begin
            if (rx == 8'hFF) begin
              phase_nxt = P_WR_TOKEN; txv = 1'b1; cs = 1'b1;
              txb = multi_r ? 8'hFC : 8'hFE;
            end else if (mst_r == '0) begin ok = 1'b0; act = 4'd3; end
            else begin txv = 1'b1; cs = 1'b1; end
          end
          P_WR_TOKEN: begin
            phase_nxt = P_WR_DATA; bidx_nxt = '0;
            wtk = 1'b1; txv = 1'b1; cs = 1'b1; txb = wr;
          end
          P_WR_DATA: begin
            bidx_nxt = bi1; txv = 1'b1; cs = 1'b1;
            if (bi1 == 10'(BlockBytes)) begin phase_nxt = P_WR_CRC; bidx_nxt = '0; end
            else begin wtk = 1'b1; txb = wr; end
          end
          P_WR_CRC: begin
            bidx_nxt = bi1; txv = 1'b1; cs = 1'b1;
            if (bi1 >= 10'd2) begin phase_nxt = P_WR_RESP; poll_nxt = '0; end
          end
          P_WR_RESP: begin
            last_nxt = rx; txv = 1'b1; cs = 1'b1;
            if (rx[4:0] != 5'h05 && poll_r < 7'd64) poll_nxt = poll_r + 7'd1;
            else begin phase_nxt = P_WR_BUSY; poll_nxt = '0; end
          end
          P_WR_BUSY: begin
            pc = poll_r + 7'd1;
            if (rx == 8'h00 && pc < 7'd64) begin poll_nxt = pc; txv = 1'b1; cs = 1'b1; end
            else begin
              if (rx == 8'h00) poll_nxt = pc;
              ok = (last_r[4:0] == 5'h05); act = 4'd3;
            end
          end
          P_STOP_READY1: begin
            txv = 1'b1;
            if (rx == 8'hFF) begin phase_nxt = P_STOP_TOKEN; cs = 1'b1; txb = 8'hFD; end
            else if (mst_r == '0) phase_nxt = P_XFER_END;
            else cs = 1'b1;
          end
          P_STOP_TOKEN: begin
            mst_nxt = tm(ready_w_r); phase_nxt = P_STOP_READY2; txv = 1'b1; cs = 1'b1;
          end
          P_STOP_READY2: begin
            txv = 1'b1;
            if (rx == 8'hFF || mst_r == '0) phase_nxt = P_XFER_END; else cs = 1'b1;
          end
          P_XFER_END: begin
            phase_nxt = P_IDLE; dn = 1'b1; fl = (left_r != '0);
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // block ends
    if (act == 4'd2 || act == 4'd3) begin
      if (ok && left_r != '0) left_nxt = left_r - 1'b1;
      txv = 1'b1;
      if (!multi_r) begin phase_nxt = P_XFER_END; cs = 1'b0; end
      else if (ok && left_nxt != '0) begin
        cs = 1'b1;
        if (act == 4'd2) begin lpt_nxt = tm(token_w_r); phase_nxt = P_RD_TOKEN; end
        else begin mst_nxt = tm(ready_w_r); phase_nxt = P_WR_READY; end
      end else begin
        cs = 1'b1; mst_nxt = tm(ready_w_r);
        if (act == 4'd2) begin
          code_nxt = 6'd12; arg_nxt = '0; resume_nxt = R_RD12; phase_nxt = P_CMD_READY;
        end else phase_nxt = P_STOP_READY1;
      end
    end

    // command completion; act 5 start cmd, 6 init_end(type in itype)
    if (act == 4'd1) begin
      lt0 = (lpt_r == '0);
      case (resume_r)
        R_CMD0: if (last_nxt == 8'h01) begin
          code_nxt = 6'd8; arg_nxt = 32'h1AA; resume_nxt = R_CMD8; act = 4'd5;
        end else begin itype_nxt = '0; act = 4'd6; end
        R_CMD8: if (last_nxt == 8'h01) begin
          phase_nxt = P_OCR8; bidx_nxt = '0; ocr_nxt = '0; txv = 1'b1; cs = 1'b1;
        end else begin
          lpt_nxt = tm(init_w_r); code_nxt = 6'd55; arg_nxt = '0; resume_nxt = R_V1_55;
          act = 4'd5;
        end
        R_V2_55, R_V2_41: begin
          if (resume_r == R_V2_55 && last_nxt <= 8'd1) begin
            code_nxt = 6'd41; arg_nxt = 32'h4000_0000; resume_nxt = R_V2_41; act = 4'd5;
          end else if (resume_r == R_V2_55 || last_nxt != 8'd0) begin
            if (!lt0) begin
              code_nxt = 6'd55; arg_nxt = '0; resume_nxt = R_V2_55; act = 4'd5;
            end else begin itype_nxt = '0; act = 4'd6; end
          end else if (!lt0) begin
            code_nxt = 6'd58; arg_nxt = '0; resume_nxt = R_V2_58; act = 4'd5;
          end else begin itype_nxt = '0; act = 4'd6; end
        end
        R_V2_58: if (last_nxt == 8'd0) begin
          phase_nxt = P_OCR58; bidx_nxt = '0; ocr_nxt = '0; txv = 1'b1; cs = 1'b1;
        end else begin itype_nxt = '0; act = 4'd6; end
        R_V1_55, R_V1_41: begin
          if (resume_r == R_V1_55 && last_nxt <= 8'd1) begin
            code_nxt = 6'd41; arg_nxt = '0; resume_nxt = R_V1_41; act = 4'd5;
          end else begin
            itype_nxt = (resume_r == R_V1_41 && last_nxt <= 8'd1) ? 3'd2 : 3'd1;
            arg_nxt = '0; act = 4'd5;
            if (itype_nxt == 3'd2) begin code_nxt = 6'd55; resume_nxt = R_V1L_55; end
            else begin code_nxt = 6'd1; resume_nxt = R_V1L_1; end
          end
        end
        R_V1L_55, R_V1L_41, R_V1L_1: begin
          if (resume_r == R_V1L_55 && last_nxt <= 8'd1) begin
            code_nxt = 6'd41; arg_nxt = '0; resume_nxt = R_V1L_41; act = 4'd5;
          end else if ((resume_r == R_V1L_55 || last_nxt != 8'd0) && !lt0) begin
            arg_nxt = '0; act = 4'd5;
            if (itype_r == 3'd2) begin code_nxt = 6'd55; resume_nxt = R_V1L_55; end
            else begin code_nxt = 6'd1; resume_nxt = R_V1L_1; end
          end else if (lt0) begin itype_nxt = '0; act = 4'd6; end
          else begin
            code_nxt = 6'd16; arg_nxt = 32'(BlockBytes); resume_nxt = R_CMD16; act = 4'd5;
          end
        end
        R_CMD16: begin
          itype_nxt = (last_nxt == 8'd0) ? itype_r : 3'd0; act = 4'd6;
        end
        R_RD_CMD: if (last_nxt == 8'd0) begin
          lpt_nxt = tm(token_w_r); phase_nxt = P_RD_TOKEN; txv = 1'b1; cs = 1'b1;
        end else begin phase_nxt = P_XFER_END; txv = 1'b1; end
        R_RD12: begin phase_nxt = P_XFER_END; txv = 1'b1; end
        R_WR55: begin
          code_nxt = 6'd23; arg_nxt = 32'(left_r); resume_nxt = R_WR23; act = 4'd5;
        end
        R_WR23: begin
          code_nxt = 6'd25; arg_nxt = addr_r; resume_nxt = R_WR_CMD; act = 4'd5;
        end
        default: if (last_nxt == 8'd0) begin
          mst_nxt = tm(ready_w_r); phase_nxt = P_WR_READY; txv = 1'b1; cs = 1'b1;
        end else begin phase_nxt = P_XFER_END; txv = 1'b1; end
      endcase
      if (act == 4'd5) begin
        mst_nxt = tm(ready_w_r); phase_nxt = P_CMD_READY; txv = 1'b1; cs = 1'b1;
      end else if (act == 4'd6) begin
        kind_nxt = itype_nxt; phase_nxt = P_INIT_END; txv = 1'b1; cs = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_w_r <= 12'd200; init_w_r <= 12'd2000; ready_w_r <= 12'd750; token_w_r <= 12'd200;
      phase_r <= P_IDLE; resume_r <= R_CMD0; bidx_r <= '0; poll_r <= '0;
      addr_r <= '0; ocr_r <= '0; arg_r <= '0; left_r <= '0; kind_r <= '0; itype_r <= '0;
      mst_r <= '0; lpt_r <= '0; last_r <= 8'hFF; code_r <= '0;
      multi_r <= 1'b0; fast_r <= 1'b0; vld_r <= 1'b0; res_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDLE:  idle_w_r  <= cfg_wdata;
          CFG_INIT:  init_w_r  <= cfg_wdata;
          CFG_READY: ready_w_r <= cfg_wdata;
          CFG_TOKEN: token_w_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (acc) begin
        phase_r <= phase_nxt; resume_r <= resume_nxt; bidx_r <= bidx_nxt; poll_r <= poll_nxt;
        addr_r <= addr_nxt; ocr_r <= ocr_nxt; arg_r <= arg_nxt; left_r <= left_nxt;
        kind_r <= kind_nxt; itype_r <= itype_nxt; mst_r <= mst_nxt; lpt_r <= lpt_nxt;
        last_r <= last_nxt; code_r <= code_nxt; multi_r <= multi_nxt; fast_r <= fast_nxt;
        res_r <= {6'd0, fast_nxt, kind_nxt, fl, dn, wtk, rdb, rdv, cs, txb, txv};
        vld_r <= 1'b1;
      end else if (out_tready) begin
        vld_r <= 1'b0;
      end
    end
  end
endmodule

// ===== bench/sd_spi_mode_host_engine_tb.sv =====
// Self-checking bench for the SD SPI-mode host engine: an emulated card answers
// each requested exchange and an in-bench predictor checks every result word.
// Depends on sdsm_pkg and the sd_spi_mode_host_engine RTL.
`timescale 1ns / 100ps

module sd_spi_mode_host_engine_tb;
  import sdsm_pkg::*;

  localparam int LIMIT_CYCLES = 1500000;
  localparam int RANDOM_ITEMS = 1950;

  // request codes above the last defined one are ignored by the block
  localparam logic [2:0] REQ_BAD_LO = 3'd5;
  localparam logic [2:0] REQ_BAD_HI = 3'd7;

  localparam logic [7:0] CMD_GO_IDLE   = 8'd0;
  localparam logic [7:0] CMD_OP_MMC    = 8'd1;
  localparam logic [7:0] CMD_SEND_IF   = 8'd8;
  localparam logic [7:0] CMD_STOP      = 8'd12;
  localparam logic [7:0] CMD_SET_BLEN  = 8'd16;
  localparam logic [7:0] CMD_RD_SINGLE = 8'd17;
  localparam logic [7:0] CMD_RD_MULTI  = 8'd18;
  localparam logic [7:0] CMD_WR_COUNT  = 8'd23;
  localparam logic [7:0] CMD_WR_SINGLE = 8'd24;
  localparam logic [7:0] CMD_WR_MULTI  = 8'd25;
  localparam logic [7:0] CMD_APP_OP    = 8'd41;
  localparam logic [7:0] CMD_APP       = 8'd55;
  localparam logic [7:0] CMD_READ_OCR  = 8'd58;

  localparam logic [7:0] TOK_START = 8'hFE;
  localparam logic [7:0] TOK_MULTI = 8'hFC;
  localparam logic [7:0] TOK_STOP  = 8'hFD;
  localparam logic [7:0] IDLE_BYTE = 8'hFF;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_MMC  = 3'd1;
  localparam logic [2:0] KIND_SDV1 = 3'd2;
  localparam logic [2:0] KIND_SDV2 = 3'd3;
  localparam logic [2:0] KIND_SDHC = 3'd4;

  typedef enum int {
    PH_IDLE, PH_PWR_CLK, PH_PWR_PRE, PH_PWR_CMD0, PH_PWR_POLL, PH_PWR_END,
    PH_CMD_READY, PH_CMD_SEND, PH_CMD_STUFF, PH_CMD_RESP, PH_OCR8, PH_OCR58,
    PH_INIT_END, PH_RD_TOKEN, PH_RD_DATA, PH_RD_CRC, PH_WR_READY, PH_WR_TOKEN,
    PH_WR_DATA, PH_WR_CRC, PH_WR_RESP, PH_WR_BUSY, PH_STOP_READY1, PH_STOP_TOKEN,
    PH_STOP_READY2, PH_XFER_END
  } phase_e;

  typedef struct packed {
    logic       fast;
    logic [2:0] kind;
    logic       failed;
    logic       done;
    logic       wr_taken;
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic       cs;
    logic [7:0] tx;
    logic       txv;
  } result_t;

  typedef struct {
    logic [2:0]  req;
    logic [31:0] sector;
    logic [15:0] count;
    logic [7:0]  rx;
    logic [7:0]  wr;
  } item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [2:0]  in_tuser = '0;   // req_type
  logic [63:0] in_tdata = '0;   // sector, block_count, rx_byte, wr_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // tx_valid, tx_byte, card_select, rd_valid, rd_byte, wr_taken, done_res,
  // failed, card_kind, fast_clock, zero pad
  logic [31:0] out_tdata;

  sd_spi_mode_host_engine uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------- engine predictor ----------------
  phase_e      ph = PH_IDLE;
  resume_t     rsm = R_CMD0;
  int unsigned bidx, polls;
  logic [2:0]  kind, itype;
  logic [31:0] caddr, arg, ocr;
  logic [15:0] bleft;
  logic [11:0] mst, loopt;
  logic [11:0] w_idle = 12'd200, w_init = 12'd2000, w_ready = 12'd750, w_token = 12'd200;
  logic [7:0]  lastr, ccode, cur_wr;
  bit          multi, fastf;
  result_t     r;

  function automatic void engine_reset();
    ph = PH_IDLE; rsm = R_CMD0; bidx = 0; polls = 0; kind = KIND_NONE;
    itype = KIND_NONE; caddr = '0; bleft = '0; mst = '0; loopt = '0; ocr = '0;
    arg = '0; lastr = IDLE_BYTE; ccode = CMD_GO_IDLE; multi = 0; fastf = 0;
  endfunction

  function automatic void emit(logic [7:0] b, logic cs);
    r.txv = 1'b1; r.tx = b; r.cs = cs;
  endfunction

  function automatic void take_wr();
    r.wr_taken = 1'b1;
    emit(cur_wr, 1'b1);
  endfunction

  function automatic void finish_req(logic fail);
    ph = PH_IDLE; r.done = 1'b1; r.failed = fail;
  endfunction

  function automatic logic [7:0] cmd_byte(int unsigned i);
    case (i)
      0: return 8'h40 | {2'b00, ccode[5:0]};
      1: return arg[31:24];
      2: return arg[23:16];
      3: return arg[15:8];
      4: return arg[7:0];
      default: return ccode == CMD_GO_IDLE ? 8'h95 : ccode == CMD_SEND_IF ? 8'h87 : 8'h01;
    endcase
  endfunction

  function automatic void cmd_start(logic [7:0] code, logic [31:0] a, resume_t back);
    ccode = code; arg = a; rsm = back; mst = w_ready; ph = PH_CMD_READY;
    emit(IDLE_BYTE, 1'b1);
  endfunction

  function automatic void init_end(logic [2:0] t);
    itype = t; kind = t; ph = PH_INIT_END;
    emit(IDLE_BYTE, 1'b0);
  endfunction

  function automatic void xfer_end();
    ph = PH_XFER_END;
    emit(IDLE_BYTE, 1'b0);
  endfunction

  function automatic void v2_after();
    if (loopt != 0) cmd_start(CMD_READ_OCR, '0, R_V2_58);
    else init_end(KIND_NONE);
  endfunction

  function automatic void v2_loop_check();
    if (loopt != 0) cmd_start(CMD_APP, '0, R_V2_55);
    else v2_after();
  endfunction

  function automatic void v1_iter();
    if (itype == KIND_SDV1) cmd_start(CMD_APP, '0, R_V1L_55);
    else cmd_start(CMD_OP_MMC, '0, R_V1L_1);
  endfunction

  function automatic void v1_after();
    if (loopt == 0) init_end(KIND_NONE);
    else cmd_start(CMD_SET_BLEN, 32'(BlockBytes), R_CMD16);
  endfunction

  function automatic void v1_loop_check();
    if (loopt != 0) v1_iter();
    else v1_after();
  endfunction

  function automatic void block_restart(bit wr);
    if (wr) begin
      mst = w_ready; ph = PH_WR_READY;
    end else begin
      loopt = w_token; ph = PH_RD_TOKEN;
    end
    emit(IDLE_BYTE, 1'b1);
  endfunction

  function automatic void read_block_end(bit ok);
    if (ok && bleft != 0) bleft = bleft - 1'b1;
    if (!multi) xfer_end();
    else if (ok && bleft != 0) block_restart(1'b0);
    else cmd_start(CMD_STOP, '0, R_RD12);
  endfunction

  function automatic void write_block_end(bit ok);
    if (ok && bleft != 0) bleft = bleft - 1'b1;
    if (!multi) xfer_end();
    else if (ok && bleft != 0) block_restart(1'b1);
    else begin
      mst = w_ready; ph = PH_STOP_READY1;
      emit(IDLE_BYTE, 1'b1);
    end
  endfunction

  function automatic void after_cmd();
    case (rsm)
      R_CMD0:
        if (lastr == 8'd1) cmd_start(CMD_SEND_IF, 32'h1AA, R_CMD8);
        else init_end(KIND_NONE);
      R_CMD8:
        if (lastr == 8'd1) begin
          ph = PH_OCR8; bidx = 0; ocr = '0;
          emit(IDLE_BYTE, 1'b1);
        end else begin
          loopt = w_init;
          cmd_start(CMD_APP, '0, R_V1_55);
        end
      R_V2_55:
        if (lastr <= 8'd1) cmd_start(CMD_APP_OP, 32'h4000_0000, R_V2_41);
        else v2_loop_check();
      R_V2_41:
        if (lastr == 8'd0) v2_after(); else v2_loop_check();
      R_V2_58:
        if (lastr == 8'd0) begin
          ph = PH_OCR58; bidx = 0; ocr = '0;
          emit(IDLE_BYTE, 1'b1);
        end else init_end(KIND_NONE);
      R_V1_55:
        if (lastr <= 8'd1) cmd_start(CMD_APP_OP, '0, R_V1_41);
        else begin
          itype = KIND_MMC;
          v1_iter();
        end
      R_V1_41: begin
        itype = (lastr <= 8'd1) ? KIND_SDV1 : KIND_MMC;
        v1_iter();
      end
      R_V1L_55:
        if (lastr <= 8'd1) cmd_start(CMD_APP_OP, '0, R_V1L_41);
        else v1_loop_check();
      R_V1L_41, R_V1L_1:
        if (lastr == 8'd0) v1_after(); else v1_loop_check();
      R_CMD16:
        init_end(lastr == 8'd0 ? itype : KIND_NONE);
      R_RD_CMD:
        if (lastr == 8'd0) block_restart(1'b0); else xfer_end();
      R_RD12:
        xfer_end();
      R_WR55:
        cmd_start(CMD_WR_COUNT, {16'h0, bleft}, R_WR23);
      R_WR23:
        cmd_start(CMD_WR_MULTI, caddr, R_WR_CMD);
      default:
        if (lastr == 8'd0) block_restart(1'b1); else xfer_end();
    endcase
  endfunction

  function automatic void start_xfer(bit wr, logic [31:0] sec, logic [15:0] cnt);
    if (cnt == 0 || kind == KIND_NONE) begin
      finish_req(1'b1);
      return;
    end
    caddr = (kind == KIND_SDHC) ? sec : sec << 9;
    bleft = cnt;
    multi = cnt != 1;
    if (!wr) cmd_start(multi ? CMD_RD_MULTI : CMD_RD_SINGLE, caddr, R_RD_CMD);
    else if (!multi) cmd_start(CMD_WR_SINGLE, caddr, R_WR_CMD);
    else if (kind >= KIND_SDV1) cmd_start(CMD_APP, '0, R_WR55);
    else cmd_start(CMD_WR_MULTI, caddr, R_WR_CMD);
  endfunction

  function automatic void on_byte(logic [7:0] rx);
    bit more;
    case (ph)
      PH_PWR_CLK: begin
        bidx++;
        if (bidx < 10) emit(IDLE_BYTE, 1'b0);
        else begin
          ph = PH_PWR_PRE; bidx = 0;
          emit(IDLE_BYTE, 1'b1);
        end
      end
      PH_PWR_PRE: begin
        bidx++;
        if (bidx < 2) emit(IDLE_BYTE, 1'b1);
        else begin
          ph = PH_PWR_CMD0; bidx = 0; ccode = CMD_GO_IDLE; arg = '0;
          emit(cmd_byte(0), 1'b1);
        end
      end
      PH_PWR_CMD0: begin
        bidx++;
        if (bidx < 6) emit(cmd_byte(bidx), 1'b1);
        else begin
          mst = w_idle; ph = PH_PWR_POLL;
          emit(IDLE_BYTE, 1'b1);
        end
      end
      PH_PWR_POLL:
        if (rx == 8'd1 || mst == 0) begin
          lastr = rx; ph = PH_PWR_END;
          emit(IDLE_BYTE, 1'b0);
        end else emit(IDLE_BYTE, 1'b1);
      PH_PWR_END:
        if (lastr == 8'd1) cmd_start(CMD_GO_IDLE, '0, R_CMD0);
        else begin
          kind = KIND_NONE;
          finish_req(1'b1);
        end
      PH_CMD_READY:
        if (rx == IDLE_BYTE) begin
          ph = PH_CMD_SEND; bidx = 0;
          emit(cmd_byte(0), 1'b1);
        end else if (mst == 0) begin
          lastr = IDLE_BYTE;
          after_cmd();
        end else emit(IDLE_BYTE, 1'b1);
      PH_CMD_SEND: begin
        bidx++;
        if (bidx < 6) emit(cmd_byte(bidx), 1'b1);
        else begin
          polls = 32;
          ph = (ccode == CMD_STOP) ? PH_CMD_STUFF : PH_CMD_RESP;
          emit(IDLE_BYTE, 1'b1);
        end
      end
      PH_CMD_STUFF: begin
        ph = PH_CMD_RESP;
        emit(IDLE_BYTE, 1'b1);
      end
      PH_CMD_RESP: begin
        if (polls != 0) polls--;
        if (rx[7] && polls != 0) emit(IDLE_BYTE, 1'b1);
        else begin
          lastr = rx;
          after_cmd();
        end
      end
      PH_OCR8, PH_OCR58: begin
        ocr = {ocr[23:0], rx};
        bidx++;
        if (bidx < 4) emit(IDLE_BYTE, 1'b1);
        else if (ph == PH_OCR58) init_end(ocr[30] ? KIND_SDHC : KIND_SDV2);
        else if (ocr[15:8] == 8'h01 && ocr[7:0] == 8'hAA) begin
          loopt = w_init;
          cmd_start(CMD_APP, '0, R_V2_55);
        end else init_end(KIND_NONE);
      end
      PH_INIT_END: begin
        fastf = itype != KIND_NONE;
        finish_req(itype == KIND_NONE);
      end
      PH_RD_TOKEN:
        if (rx == IDLE_BYTE && loopt != 0) emit(IDLE_BYTE, 1'b1);
        else if (rx != TOK_START) read_block_end(1'b0);
        else begin
          ph = PH_RD_DATA; bidx = 0;
          emit(IDLE_BYTE, 1'b1);
        end
      PH_RD_DATA: begin
        r.rd_valid = 1'b1; r.rd_byte = rx;
        bidx++;
        if (bidx < BlockBytes) emit(IDLE_BYTE, 1'b1);
        else begin
          ph = PH_RD_CRC; bidx = 0;
          emit(IDLE_BYTE, 1'b1);
        end
      end
      PH_RD_CRC: begin
        bidx++;
        if (bidx < 2) emit(IDLE_BYTE, 1'b1); else read_block_end(1'b1);
      end
      PH_WR_READY:
        if (rx == IDLE_BYTE) begin
          ph = PH_WR_TOKEN;
          emit(multi ? TOK_MULTI : TOK_START, 1'b1);
        end else if (mst == 0) write_block_end(1'b0);
        else emit(IDLE_BYTE, 1'b1);
      PH_WR_TOKEN: begin
        ph = PH_WR_DATA; bidx = 0;
        take_wr();
      end
      PH_WR_DATA: begin
        bidx++;
        if (bidx < BlockBytes) take_wr();
        else begin
          ph = PH_WR_CRC; bidx = 0;
          emit(IDLE_BYTE, 1'b1);
        end
      end
      PH_WR_CRC: begin
        bidx++;
        if (bidx < 2) emit(IDLE_BYTE, 1'b1);
        else begin
          ph = PH_WR_RESP; polls = 0;
          emit(IDLE_BYTE, 1'b1);
        end
      end
      PH_WR_RESP: begin
        lastr = rx;
        more = 0;
        if (rx[4:0] != 5'h05) begin
          polls++;
          more = polls <= 64;
        end
        if (!more) begin
          ph = PH_WR_BUSY; polls = 0;
        end
        emit(IDLE_BYTE, 1'b1);
      end
      PH_WR_BUSY: begin
        more = 0;
        if (rx == 8'd0) begin
          polls++;
          more = polls < 64;
        end
        if (more) emit(IDLE_BYTE, 1'b1);
        else write_block_end(lastr[4:0] == 5'h05);
      end
      PH_STOP_READY1:
        if (rx == IDLE_BYTE) begin
          ph = PH_STOP_TOKEN;
          emit(TOK_STOP, 1'b1);
        end else if (mst == 0) xfer_end();
        else emit(IDLE_BYTE, 1'b1);
      PH_STOP_TOKEN: begin
        mst = w_ready; ph = PH_STOP_READY2;
        emit(IDLE_BYTE, 1'b1);
      end
      PH_STOP_READY2:
        if (rx == IDLE_BYTE || mst == 0) xfer_end(); else emit(IDLE_BYTE, 1'b1);
      PH_XFER_END:
        finish_req(bleft != 0);
      default: ;
    endcase
  endfunction

  function automatic result_t engine_step(item_t it);
    r = '0;
    r.tx = IDLE_BYTE;
    cur_wr = it.wr;
    if (it.req == REQ_INIT && ph == PH_IDLE) begin
      kind = KIND_NONE; itype = KIND_NONE; fastf = 0; ph = PH_PWR_CLK; bidx = 0;
      emit(IDLE_BYTE, 1'b0);
    end else if ((it.req == REQ_READ || it.req == REQ_WRITE) && ph == PH_IDLE) begin
      start_xfer(it.req == REQ_WRITE, it.sector, it.count);
    end else if (it.req == REQ_BYTE) begin
      on_byte(it.rx);
    end else if (it.req == REQ_TICK) begin
      if (mst != 0) mst--;
      if (loopt != 0) loopt--;
    end
    r.kind = kind;
    r.fast = fastf;
    return r;
  endfunction

  // ---------------- stimulus ----------------
  item_t   pending_items[$];
  result_t expected_results[$];
  int      n_items;
  int      errors;
  logic [2:0] card_target;
  bit      force_error;

  task automatic send(logic [2:0] req, logic [31:0] sec, logic [15:0] cnt, logic [7:0] rx);
    item_t it;
    it.req = req; it.sector = sec; it.count = cnt; it.rx = rx; it.wr = 8'($urandom);
    pending_items.push_back(it);
    expected_results.push_back(engine_step(it));
    n_items++;
  endtask

  // what a well-behaved (or, with force_error, failing) card returns next
  function automatic logic [7:0] card_reply();
    int p;
    p = $urandom_range(0, 99);
    if (p < 4) return 8'($urandom);
    case (ph)
      PH_PWR_POLL:   return p < 70 ? 8'd1 : IDLE_BYTE;
      PH_CMD_READY, PH_WR_READY, PH_STOP_READY1, PH_STOP_READY2:
        return p < 80 ? IDLE_BYTE : 8'd0;
      PH_CMD_RESP: begin
        if (p < 30) return IDLE_BYTE;
        case (rsm)
          R_CMD0:   return 8'd1;
          R_CMD8:   return card_target >= KIND_SDV2 ? 8'd1 : 8'h05;
          R_V2_55, R_V1L_55, R_WR55: return 8'd1;
          R_V2_41, R_V1L_41, R_V1L_1: return p < 80 ? 8'd0 : 8'd1;
          R_V1_55, R_V1_41: return card_target == KIND_SDV1 ? 8'd1 : 8'h05;
          default:  return 8'd0;
        endcase
      end
      PH_OCR8:
        return bidx == 2 ? 8'h01 : bidx == 3 ? 8'hAA : 8'h00;
      PH_OCR58:
        return bidx == 0 ? (card_target == KIND_SDHC ? 8'hC0 : 8'h80) : 8'($urandom);
      PH_RD_TOKEN:
        return force_error ? 8'h0B : p < 75 ? TOK_START : IDLE_BYTE;
      PH_WR_RESP:
        return force_error ? 8'h0B : p < 70 ? 8'hE5 : IDLE_BYTE;
      PH_WR_BUSY:    return p < 60 ? 8'd0 : IDLE_BYTE;
      default:       return 8'($urandom);
    endcase
  endfunction

  task automatic run_request();
    int steps;
    int p;
    steps = 0;
    while (ph != PH_IDLE && steps < 8000 && n_items < RANDOM_ITEMS) begin
      p = $urandom_range(0, 99);
      if (p < 3) send(REQ_TICK, $urandom, 16'($urandom), 8'($urandom));
      else if (p < 5)
        send($urandom_range(0, 1) ? REQ_WRITE : REQ_INIT, $urandom, 16'd1, 8'($urandom));
      else if (p < 6)
        send(3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI)), $urandom, 16'($urandom),
             8'($urandom));
      else send(REQ_BYTE, $urandom, 16'($urandom), card_reply());
      steps++;
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] val);
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_IDLE:  w_idle = val;
      CFG_INIT:  w_init = val;
      CFG_READY: w_ready = val;
      default:   w_token = val;
    endcase
  endtask

  function automatic logic [11:0] pick_wait();
    int p;
    p = $urandom_range(0, 3);
    return p == 0 ? 12'd1 : p == 1 ? 12'd4095 : 12'($urandom_range(1, 40));
  endfunction

  function automatic logic [31:0] pick_sector();
    int p;
    p = $urandom_range(0, 3);
    return p == 0 ? 32'h0 : p == 1 ? 32'hFFFF_FFFF : 32'($urandom);
  endfunction

  initial begin
    logic [15:0] cnt;
    int p;
    int target;
    engine_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: stray and ignored items, transfers with no card, zero count
    send(REQ_BYTE, '0, '0, 8'h00);
    send(REQ_BAD_LO, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
    send(REQ_BAD_HI, '0, '0, '0);
    send(REQ_TICK, '0, '0, '0);
    send(REQ_READ, 32'hFFFF_FFFF, 16'd1, '0);
    send(REQ_WRITE, 32'h0, 16'hFFFF, '0);
    force_error = 0;
    card_target = KIND_SDHC;
    send(REQ_INIT, '0, '0, '0);
    run_request();
    send(REQ_READ, 32'h1234_5678, 16'd0, '0);
    write_reg(CFG_IDLE, 12'd4095);
    write_reg(CFG_INIT, 12'd4095);
    write_reg(CFG_READY, 12'd1);
    write_reg(CFG_TOKEN, 12'd1);

    target = RANDOM_ITEMS;
    while (n_items < target) begin
      p = $urandom_range(0, 99);
      if (p < 20) write_reg(2'($urandom_range(0, 3)), pick_wait());
      force_error = 0;
      if (kind == KIND_NONE || $urandom_range(0, 3) == 0) begin
        card_target = 3'($urandom_range(KIND_MMC, KIND_SDHC));
        send(REQ_INIT, pick_sector(), 16'($urandom), 8'($urandom));
      end else begin
        p = $urandom_range(0, 99);
        if (p < 10) cnt = 16'd0;
        else if (p < 20) begin
          cnt = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(4, 65534));
          force_error = 1;
        end else begin
          cnt = 16'($urandom_range(1, 2));
          force_error = $urandom_range(0, 4) == 0;
        end
        send($urandom_range(0, 1) ? REQ_WRITE : REQ_READ, pick_sector(), cnt, 8'($urandom));
      end
      run_request();
    end

    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // ---------------- drive and check ----------------
  int  cycles;
  bit  calm;
  bit  in_taken;
  int  in_gap, out_gap;

  function automatic int pick_gap();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    return p < 60 ? 0 : p < 95 ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles % 600 == 0) calm = $urandom_range(0, 2) == 0;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) begin
    item_t it;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        it = pending_items.pop_front();
        in_tuser <= it.req;
        in_tdata <= {it.wr, it.rx, it.count, it.sector};
        in_tvalid <= 1'b1;
        in_gap = pick_gap();
      end else in_tvalid <= 1'b0;
    end
    if (!rst_n) out_tready <= 1'b0;
    else if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 4) == 0) out_gap = pick_gap();
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    result_t e, a;
    in_taken = in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      a = out_tdata[25:0];
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected: %0h", out_tdata);
        errors++;
      end else begin
        e = expected_results.pop_front();
        check_field("tx_valid", 32'(e.txv), 32'(a.txv));
        check_field("tx_byte", 32'(e.tx), 32'(a.tx));
        check_field("card_select", 32'(e.cs), 32'(a.cs));
        check_field("rd_valid", 32'(e.rd_valid), 32'(a.rd_valid));
        check_field("rd_byte", 32'(e.rd_byte), 32'(a.rd_byte));
        check_field("wr_taken", 32'(e.wr_taken), 32'(a.wr_taken));
        check_field("done_res", 32'(e.done), 32'(a.done));
        check_field("failed", 32'(e.failed), 32'(a.failed));
        check_field("card_kind", 32'(e.kind), 32'(a.kind));
        check_field("fast_clock", 32'(e.fast), 32'(a.fast));
        check_field("pad", '0, 32'(out_tdata[31:26]));
      end
    end
  end

endmodule
